// File: sv/stk_pkg.sv
// stk_pkg: shared types and constants for the streaming top-k tracker.
// Used by stk_ctrl, stk_datapath and streaming_top_k_tracker; no dependencies.
package stk_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned KEEP_W = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIM,
        ST_READ,
        ST_EMPTY
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic ins;         // insert the input value in order
        logic drop;        // drop the smallest held value
        logic rd_load;     // start a read run, load the word counter
        logic rd_step;     // emit the smallest entry, rotate the store by one
        logic empty_emit;  // emit the empty-store word
    } stk_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;  // nothing held
        logic over_keep;   // more held than the effective keep count
        logic rem_last;    // one word left in the current read run
        logic slot_free;   // output register can take a word this cycle
    } stk_status_t;

endpackage

// File: sv/stk_ctrl.sv
// stk_ctrl: sequencer for inserts, trimming and read runs.
// Depends on stk_pkg (state_t, stk_cmd_t, stk_status_t).
module stk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_func,
    output logic                in_ready,
    input  stk_pkg::stk_status_t status,
    output stk_pkg::stk_cmd_t    cmd
);

    stk_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            stk_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == stk_pkg::FUNC_INSERT)
                    begin
                        cmd.ins = 1'b1;
                        // store stays over the keep count only if keep was lowered
                        if (status.over_keep)
                        begin
                            state_next = stk_pkg::ST_TRIM;
                        end
                    end
                    else if (status.count_zero)
                    begin
                        state_next = stk_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.rd_load = 1'b1;
                        state_next  = stk_pkg::ST_READ;
                    end
                end
            end
            stk_pkg::ST_TRIM:
            begin
                if (status.over_keep)
                begin
                    cmd.drop = 1'b1;
                end
                else
                begin
                    state_next = stk_pkg::ST_IDLE;
                end
            end
            stk_pkg::ST_READ:
            begin
                if (status.slot_free)
                begin
                    cmd.rd_step = 1'b1;
                    if (status.rem_last)
                    begin
                        state_next = stk_pkg::ST_IDLE;
                    end
                end
            end
            stk_pkg::ST_EMPTY:
            begin
                if (status.slot_free)
                begin
                    cmd.empty_emit = 1'b1;
                    state_next     = stk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/stk_datapath.sv
// stk_datapath: sorted value store, held/remaining counters, keep register
// and output register. Depends on stk_pkg (widths, stk_cmd_t, stk_status_t).
module stk_datapath #(
    parameter int unsigned MAX_KEEP = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [stk_pkg::KEEP_W-1:0]          cfg_wr_data,
    input  logic signed [stk_pkg::DATA_W-1:0]   in_value,
    input  stk_pkg::stk_cmd_t                   cmd,
    output stk_pkg::stk_status_t                status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [stk_pkg::DATA_W-1:0]   out_value,
    output logic                                out_last,
    output logic                                out_empty
);

    localparam int unsigned CW = $clog2(MAX_KEEP + 1);
    localparam int unsigned KW = (CW > stk_pkg::KEEP_W) ? CW : stk_pkg::KEEP_W;

    logic signed [stk_pkg::DATA_W-1:0] kv_reg  [MAX_KEEP];
    logic signed [stk_pkg::DATA_W-1:0] kv_next [MAX_KEEP];
    logic signed [stk_pkg::DATA_W-1:0] work    [MAX_KEEP+1];
    logic [MAX_KEEP-1:0]               le;

    logic [CW-1:0]                 cnt_reg, cnt_next, cnt_m1;
    logic [CW-1:0]                 rem_reg, rem_next;
    logic [stk_pkg::KEEP_W-1:0]    keep_reg;
    logic [KW-1:0]                 keep_ext, k_eff, cnt_ext;
    logic                          full_ins;

    logic                          ovalid_reg;
    logic signed [stk_pkg::DATA_W-1:0] odata_reg;
    logic                          olast_reg, oempty_reg;

    // keep count clamped to the store depth
    assign keep_ext = KW'(keep_reg);
    assign k_eff    = (keep_ext > KW'(MAX_KEEP)) ? KW'(MAX_KEEP) : keep_ext;
    assign cnt_ext  = KW'(cnt_reg);
    assign cnt_m1   = cnt_reg - 1'b1;
    // insert into a store already at keep: new value goes in, smallest goes out
    assign full_ins = (cnt_ext >= k_eff);

    // le[j]: entry j is held and not above the new value (a prefix, store is sorted)
    genvar j;
    generate
        for (j = 0; j < MAX_KEEP; j++)
        begin : g_le
            assign le[j] = (CW'(j) < cnt_reg) && (kv_reg[j] <= in_value);
        end
    endgenerate

    // store with the value inserted, one entry longer
    generate
        for (j = 0; j <= MAX_KEEP; j++)
        begin : g_work
            if (j == 0)
            begin : g_first
                assign work[j] = le[j] ? kv_reg[j] : in_value;
            end
            else if (j == MAX_KEEP)
            begin : g_tail
                assign work[j] = le[j-1] ? in_value : kv_reg[j-1];
            end
            else
            begin : g_mid
                assign work[j] = le[j] ? kv_reg[j] :
                                 (le[j-1] ? in_value : kv_reg[j-1]);
            end
        end
    endgenerate

    // per-entry next value
    generate
        for (j = 0; j < MAX_KEEP; j++)
        begin : g_next
            logic signed [stk_pkg::DATA_W-1:0] up_val;
            if (j < MAX_KEEP - 1)
            begin : g_up
                assign up_val = kv_reg[j+1];
            end
            else
            begin : g_hold
                assign up_val = kv_reg[j];
            end

            always_comb
            begin
                kv_next[j] = kv_reg[j];
                if (cmd.ins)
                begin
                    kv_next[j] = full_ins ? work[j+1] : work[j];
                end
                else if (cmd.drop)
                begin
                    kv_next[j] = up_val;
                end
                else if (cmd.rd_step)
                begin
                    // rotate the held entries; after a full run the order is back
                    if (CW'(j) == cnt_m1)
                    begin
                        kv_next[j] = kv_reg[0];
                    end
                    else if (CW'(j) < cnt_m1)
                    begin
                        kv_next[j] = up_val;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.ins && !full_ins)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.drop)
        begin
            cnt_next = cnt_m1;
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        if (cmd.rd_load)
        begin
            rem_next = cnt_reg;
        end
        else if (cmd.rd_step)
        begin
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            kv_reg[i] <= kv_next[i];
        end
        if (cmd.rd_step)
        begin
            odata_reg  <= kv_reg[0];
            olast_reg  <= (rem_reg == CW'(1));
            oempty_reg <= 1'b0;
        end
        else if (cmd.empty_emit)
        begin
            odata_reg  <= '0;
            olast_reg  <= 1'b1;
            oempty_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rem_reg    <= '0;
            keep_reg   <= stk_pkg::KEEP_W'(1);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            if (cfg_wr_en)
            begin
                keep_reg <= cfg_wr_data;
            end
            if (cmd.rd_step || cmd.empty_emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign status.count_zero = (cnt_reg == '0);
    assign status.over_keep  = (cnt_ext > k_eff);
    assign status.rem_last   = (rem_reg == CW'(1));
    assign status.slot_free  = !ovalid_reg || out_ready;

    assign out_valid = ovalid_reg;
    assign out_value = odata_reg;
    assign out_last  = olast_reg;
    assign out_empty = oempty_reg;

endmodule

// File: sv/streaming_top_k_tracker.sv
// streaming_top_k_tracker: top level, controller plus datapath.
// Depends on stk_pkg, stk_ctrl and stk_datapath.
//
// Keeps the keep_count largest signed 32-bit values seen, sorted ascending.
// Input stream s_*: s_tuser = func (0 insert s_tdata, 1 read out the store).
// Output stream m_*: one word per held value, smallest first, m_tlast on the
// final word of a run. A read with nothing held gives one word with
// m_tuser (empty) set, m_tlast set and m_tdata zero.
// Config: cfg_wr_en/cfg_wr_data write keep_count (values above MAX_KEEP act
// as MAX_KEEP); write it only while the block is idle.
// Operation: an insert is one parallel compare/shift over the store. After
// keep_count was lowered, the next insert is followed by a trim state that
// drops the extra values one by one and then returns to idle. A read loads
// the word counter, then emits one word per held value through the output
// register; each word is registered in the cycle after its step.
// Stalls: when m_tready is low the output register holds its word and the
// read run waits; s_tready is high only while the sequencer is idle, and it
// stays high while a last word still waits in the output register.
// Reset: held count zero, keep_count 1, output empty. The store itself is
// not cleared; only held entries are ever read.
module streaming_top_k_tracker #(
    parameter int unsigned MAX_KEEP = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // config: keep_count
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] func
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_out
    output logic        m_tlast,   // last word of a read run
    output logic        m_tuser    // [0] empty_res
);

    stk_pkg::stk_cmd_t    cmd;
    stk_pkg::stk_status_t status;

    logic signed [31:0] value_out;

    stk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stk_datapath #(
        .MAX_KEEP (MAX_KEEP)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_value    (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_value   (value_out),
        .out_last    (m_tlast),
        .out_empty   (m_tuser)
    );

    assign m_tdata = value_out;

    // empty-store word is always a one-word run with zero data
    a_empty_word : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 32'd0)))
        else $error("empty word without last or with nonzero data");

    // a word is only loaded when the output register can take it
    a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_step || cmd.empty_emit) |-> status.slot_free)
        else $error("output word overwritten while stalled");

    // at most one store command per cycle
    a_one_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ins, cmd.drop, cmd.rd_load, cmd.rd_step, cmd.empty_emit}))
        else $error("conflicting datapath commands");

    // no input is taken while a read run is still being emitted
    a_run_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_load) |=> !s_tready)
        else $error("input accepted during a read run");

endmodule

// File: bench/streaming_top_k_tracker_tb.sv
// streaming_top_k_tracker_tb: self-checking bench for the top-k tracker.
// Depends on stk_pkg and streaming_top_k_tracker; a scoreboard class holds
// its own sorted store and checks every read-out word against it.
`timescale 1ns / 100ps

module streaming_top_k_tracker_tb;

    localparam int unsigned KEEP_DEPTH = 16;
    // cycles allowed after the last result for trim work to finish
    localparam int unsigned SETTLE = 24;
    // cycles with no word moving on either side before giving up
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PHASE_WORDS = 18;
    localparam int unsigned READ_PCT = 20;

    typedef struct {
        logic [stk_pkg::DATA_W-1:0] value;
        logic                       last;
        logic                       empty;
    } top_k_word_t;

    // Scoreboard: mirrors the retained set, smallest first, and queues the
    // words each read must produce.
    class top_k_scoreboard;
        logic signed [stk_pkg::DATA_W-1:0] retained[$];
        top_k_word_t                       read_q[$];
        int unsigned                       keep_eff;
        int                                errors;

        function new();
            keep_eff = 1;
            errors   = 0;
        endfunction

        function void set_keep(logic [stk_pkg::KEEP_W-1:0] k);
            keep_eff = (k > KEEP_DEPTH) ? KEEP_DEPTH : k;
        endfunction

        function int pending();
            return read_q.size();
        endfunction

        function void note_input(logic func, logic signed [stk_pkg::DATA_W-1:0] v);
            int          pos;
            top_k_word_t w;
            if (func == stk_pkg::FUNC_INSERT)
            begin
                // equal values go after existing ones; trim only on insert
                pos = 0;
                while (pos < retained.size() && retained[pos] <= v)
                    pos++;
                retained.insert(pos, v);
                while (retained.size() > keep_eff)
                    void'(retained.pop_front());
            end
            else if (retained.size() == 0)
            begin
                w.value = '0;
                w.last  = 1'b1;
                w.empty = 1'b1;
                read_q.insert(read_q.size(), w);
            end
            else
            begin
                foreach (retained[i])
                begin
                    w.value = retained[i];
                    w.last  = (i == retained.size() - 1);
                    w.empty = 1'b0;
                    read_q.insert(read_q.size(), w);
                end
            end
        endfunction

        function void check_result(logic [stk_pkg::DATA_W-1:0] value, logic last,
                                   logic empty);
            top_k_word_t w;
            if (read_q.size() == 0)
            begin
                $error("unexpected result word: value_out %0d last %0b empty_res %0b",
                       $signed(value), last, empty);
                errors++;
                return;
            end
            w = read_q.pop_front();
            if (value !== w.value)
            begin
                $error("value_out expected %0d got %0d", $signed(w.value), $signed(value));
                errors++;
            end
            if (last !== w.last)
            begin
                $error("last expected %0b got %0b", w.last, last);
                errors++;
            end
            if (empty !== w.empty)
            begin
                $error("empty_res expected %0b got %0b", w.empty, empty);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [stk_pkg::KEEP_W-1:0] cfg_wr_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [stk_pkg::DATA_W-1:0] s_tdata;    // [31:0] value
    logic                       s_tuser;    // [0] func
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [stk_pkg::DATA_W-1:0] m_tdata;    // [31:0] value_out
    logic                       m_tlast;    // last word of a read run
    logic                       m_tuser;    // [0] empty_res

    // idle percentages per cycle for the sender and the receiver
    int unsigned src_gap_pct;
    int unsigned sink_stall_pct;
    int unsigned quiet_cycles = 0;

    top_k_scoreboard sb = new();

    streaming_top_k_tracker #(
        .MAX_KEEP    (KEEP_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: ready changes on the falling edge only.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Every result word is checked at the edge where it is taken.
    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    // Watchdog: nothing moving on either side for too long ends the run.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[streaming_top_k_tracker] ERROR");
            $finish;
        end
    end

    // Random value: mostly full range, some extremes, some small values so
    // that duplicates show up often.
    function automatic logic [stk_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return stk_pkg::DATA_W'(int'($urandom_range(15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Present one word; returns after the edge where it was accepted.
    // Valid stays high so back-to-back words need no extra assignment.
    task automatic send_word(input logic func, input logic [stk_pkg::DATA_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(func, value);
    endtask

    // Stop sending, wait for every queued read word, then extra cycles.
    task automatic wait_idle(input int unsigned extra);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // keep_count may only change with the block idle, including trim work.
    task automatic write_keep(input logic [stk_pkg::KEEP_W-1:0] k);
        wait_idle(SETTLE);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_keep(k);
    endtask

    task automatic set_idle_mode(input int unsigned phase_idx);
        if (phase_idx < 4)
        begin
            src_gap_pct    = 10;
            sink_stall_pct = 64;
        end
        else if (phase_idx < 8)
        begin
            src_gap_pct    = 64;
            sink_stall_pct = 10;
        end
        else
        begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
        end
    endtask

    logic [stk_pkg::KEEP_W-1:0] phase_keep[12] = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd12,
                                                   5'd16, 5'd2, 5'd7, 5'd17, 5'd9, 5'd3};

    initial
    begin
        logic is_read;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = stk_pkg::FUNC_INSERT;
        set_idle_mode(0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // Read with nothing held: one empty word.
        send_word(stk_pkg::FUNC_READ, 32'hdead_beef);
        // Reset keep of one: the smaller value drops straight away.
        send_word(stk_pkg::FUNC_INSERT, 32'h7fff_ffff);
        send_word(stk_pkg::FUNC_INSERT, 32'h8000_0000);
        send_word(stk_pkg::FUNC_READ, '0);

        // Full depth: extremes, zero, signs and duplicates.
        write_keep(5'd16);
        send_word(stk_pkg::FUNC_INSERT, 32'h8000_0000);
        send_word(stk_pkg::FUNC_INSERT, 32'h7fff_ffff);
        send_word(stk_pkg::FUNC_INSERT, 32'h0000_0000);
        send_word(stk_pkg::FUNC_INSERT, 32'hffff_ffff);
        send_word(stk_pkg::FUNC_INSERT, 32'h0000_0001);
        send_word(stk_pkg::FUNC_INSERT, 32'h0000_0005);
        send_word(stk_pkg::FUNC_INSERT, 32'h0000_0005);
        send_word(stk_pkg::FUNC_INSERT, 32'h0000_0005);
        send_word(stk_pkg::FUNC_INSERT, 32'hffff_ff9c);
        send_word(stk_pkg::FUNC_READ, $urandom);

        // Lower keep with many values held: a read still shows them all,
        // the next insert trims down to the new count.
        write_keep(5'd3);
        send_word(stk_pkg::FUNC_READ, '0);
        send_word(stk_pkg::FUNC_INSERT, 32'h0000_0007);
        send_word(stk_pkg::FUNC_READ, '0);

        // Keep of zero: an insert leaves the store empty.
        write_keep(5'd0);
        send_word(stk_pkg::FUNC_INSERT, 32'h0000_0009);
        send_word(stk_pkg::FUNC_READ, '0);

        // Keep above the depth acts as the depth.
        write_keep(5'd31);
        for (int i = 0; i < 18; i++)
            send_word(stk_pkg::FUNC_INSERT, rand_value());
        send_word(stk_pkg::FUNC_READ, '0);

        // ---- random part: one keep setting per phase ----
        foreach (phase_keep[p])
        begin
            write_keep(phase_keep[p]);
            set_idle_mode(p);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                is_read = ($urandom_range(99) < READ_PCT);
                send_word(is_read ? stk_pkg::FUNC_READ : stk_pkg::FUNC_INSERT,
                          rand_value());
                // now and then hold off until the read run has drained
                if (is_read && $urandom_range(9) == 0)
                    wait_idle(0);
            end
        end

        wait_idle(SETTLE);
        if (sb.errors == 0)
            $display("[streaming_top_k_tracker] OK");
        else
            $display("[streaming_top_k_tracker] ERROR");
        $finish;
    end

endmodule

// File: streaming_top_k_tracker.f
sv/stk_pkg.sv
sv/stk_ctrl.sv
sv/stk_datapath.sv
sv/streaming_top_k_tracker.sv
bench/streaming_top_k_tracker_tb.sv
